### rtl/gzhs_pkg.sv
// Package for the gzip header skipper: phase codes, header constants, result type.
// No dependencies; used by gzhs_parser and gzip_header_skipper_unit.
`default_nettype none

package gzhs_pkg;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_TRAIL   = 4'd1;
    localparam logic [3:0] PH_ID1     = 4'd2;
    localparam logic [3:0] PH_ID2     = 4'd3;
    localparam logic [3:0] PH_CM      = 4'd4;
    localparam logic [3:0] PH_FLG     = 4'd5;
    localparam logic [3:0] PH_FIXED   = 4'd6;
    localparam logic [3:0] PH_XLEN    = 4'd7;
    localparam logic [3:0] PH_EXTRA   = 4'd8;
    localparam logic [3:0] PH_NAME    = 4'd9;
    localparam logic [3:0] PH_COMMENT = 4'd10;
    localparam logic [3:0] PH_CRC     = 4'd11;
    localparam logic [3:0] PH_ERROR   = 4'd12;

    localparam logic [7:0] GZ_ID1 = 8'd31;
    localparam logic [7:0] GZ_ID2 = 8'd139;

    // FLG bit positions
    localparam int FL_FHCRC  = 1;
    localparam int FL_FEXTRA = 2;
    localparam int FL_FNAME  = 3;
    localparam int FL_FCOMM  = 4;

    localparam logic [3:0] MAX_TRAILER = 4'd8;
    localparam logic [2:0] FIXED_LEN   = 3'd6;  // MTIME(4) + XFL + OS
    localparam logic [2:0] TWO_BYTES   = 3'd2;

    typedef struct packed {
        logic       header_done;
        logic       bad_magic;
        logic [3:0] phase;
        logic [7:0] header_flags;
    } gzhs_result_t;

endpackage : gzhs_pkg

`default_nettype wire

### rtl/gzhs_parser.sv
// Header walk state and one-byte next-state logic of the gzip header skipper.
// Depends on gzhs_pkg.
`default_nettype none

module gzhs_parser (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step_en,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 begin_req,
    input  wire logic [3:0]           skip_count,
    output gzhs_pkg::gzhs_result_t    result
);

    logic [3:0]  phase_reg,   phase_next;
    logic [3:0]  trail_reg,   trail_next;
    logic [2:0]  fixed_reg,   fixed_next;
    logic [7:0]  flag_reg,    flag_next;
    logic [15:0] extra_reg,   extra_next;
    logic        idok_reg,    idok_next;

    // state as seen after a begin mark is applied
    logic [3:0]  phase_e, trail_e;
    logic [2:0]  fixed_e;
    logic [7:0]  flag_e;
    logic [15:0] extra_e;
    logic        idok_e;
    logic [3:0]  sk_sat;
    logic [3:0]  trail_dec;
    logic [2:0]  fixed_dec;
    logic [15:0] extra_dec;
    logic [15:0] xlen_full;
    logic        done;
    logic        bad;
    logic [3:0]  ph_out;

    // first enabled optional section at or after stage; idle means header ends
    function automatic logic [3:0] first_section(input logic [3:0] stage,
                                                 input logic [7:0] flg);
        logic [3:0] nx;
        nx = gzhs_pkg::PH_IDLE;
        if (stage <= gzhs_pkg::PH_XLEN && flg[gzhs_pkg::FL_FEXTRA])
            nx = gzhs_pkg::PH_XLEN;
        else if (stage <= gzhs_pkg::PH_NAME && flg[gzhs_pkg::FL_FNAME])
            nx = gzhs_pkg::PH_NAME;
        else if (stage <= gzhs_pkg::PH_COMMENT && flg[gzhs_pkg::FL_FCOMM])
            nx = gzhs_pkg::PH_COMMENT;
        else if (stage <= gzhs_pkg::PH_CRC && flg[gzhs_pkg::FL_FHCRC])
            nx = gzhs_pkg::PH_CRC;
        return nx;
    endfunction

    assign sk_sat = (skip_count > gzhs_pkg::MAX_TRAILER) ? gzhs_pkg::MAX_TRAILER
                                                         : skip_count;

    always_comb begin
        if (begin_req) begin
            phase_e = (sk_sat != 4'd0) ? gzhs_pkg::PH_TRAIL : gzhs_pkg::PH_ID1;
            trail_e = sk_sat;
            fixed_e = 3'd0;
            flag_e  = 8'd0;
            extra_e = 16'd0;
            idok_e  = 1'b0;
        end else begin
            phase_e = phase_reg;
            trail_e = trail_reg;
            fixed_e = fixed_reg;
            flag_e  = flag_reg;
            extra_e = extra_reg;
            idok_e  = idok_reg;
        end
    end

    assign trail_dec = (trail_e != 4'd0) ? trail_e - 4'd1 : trail_e;
    assign fixed_dec = (fixed_e != 3'd0) ? fixed_e - 3'd1 : fixed_e;
    assign extra_dec = (extra_e != 16'd0) ? extra_e - 16'd1 : extra_e;
    assign xlen_full = extra_e | {data_byte, 8'd0};

    always_comb begin
        logic [3:0] nx;
        nx         = gzhs_pkg::PH_IDLE;
        phase_next = phase_e;
        trail_next = trail_e;
        fixed_next = fixed_e;
        flag_next  = flag_e;
        extra_next = extra_e;
        idok_next  = idok_e;
        done       = 1'b0;
        bad        = 1'b0;
        ph_out     = phase_e;
        unique case (phase_e)
            gzhs_pkg::PH_IDLE: begin
            end
            gzhs_pkg::PH_TRAIL: begin
                trail_next = trail_dec;
                if (trail_dec == 4'd0) phase_next = gzhs_pkg::PH_ID1;
            end
            gzhs_pkg::PH_ID1: begin
                idok_next  = (data_byte == gzhs_pkg::GZ_ID1);
                phase_next = gzhs_pkg::PH_ID2;
            end
            gzhs_pkg::PH_ID2: begin
                if (idok_e && data_byte == gzhs_pkg::GZ_ID2) begin
                    phase_next = gzhs_pkg::PH_CM;
                end else begin
                    bad        = 1'b1;
                    phase_next = gzhs_pkg::PH_ERROR;
                end
            end
            gzhs_pkg::PH_CM: begin
                phase_next = gzhs_pkg::PH_FLG;
            end
            gzhs_pkg::PH_FLG: begin
                flag_next  = data_byte;
                fixed_next = gzhs_pkg::FIXED_LEN;
                phase_next = gzhs_pkg::PH_FIXED;
            end
            gzhs_pkg::PH_FIXED: begin
                fixed_next = fixed_dec;
                if (fixed_dec == 3'd0) nx = first_section(gzhs_pkg::PH_XLEN, flag_e);
                if (fixed_dec == 3'd0) begin
                    phase_next = nx;
                    done       = (nx == gzhs_pkg::PH_IDLE);
                end
            end
            gzhs_pkg::PH_XLEN: begin
                if (fixed_e >= gzhs_pkg::TWO_BYTES) begin
                    extra_next = {8'd0, data_byte};
                    fixed_next = 3'd1;
                end else begin
                    extra_next = xlen_full;
                    fixed_next = 3'd0;
                    if (xlen_full == 16'd0) begin
                        nx         = first_section(gzhs_pkg::PH_NAME, flag_e);
                        phase_next = nx;
                        done       = (nx == gzhs_pkg::PH_IDLE);
                    end else begin
                        phase_next = gzhs_pkg::PH_EXTRA;
                    end
                end
            end
            gzhs_pkg::PH_EXTRA: begin
                extra_next = extra_dec;
                if (extra_dec == 16'd0) begin
                    nx         = first_section(gzhs_pkg::PH_NAME, flag_e);
                    phase_next = nx;
                    done       = (nx == gzhs_pkg::PH_IDLE);
                end
            end
            gzhs_pkg::PH_NAME: begin
                if (data_byte == 8'd0) begin
                    nx         = first_section(gzhs_pkg::PH_COMMENT, flag_e);
                    phase_next = nx;
                    done       = (nx == gzhs_pkg::PH_IDLE);
                end
            end
            gzhs_pkg::PH_COMMENT: begin
                if (data_byte == 8'd0) begin
                    nx         = first_section(gzhs_pkg::PH_CRC, flag_e);
                    phase_next = nx;
                    done       = (nx == gzhs_pkg::PH_IDLE);
                end
            end
            gzhs_pkg::PH_CRC: begin
                fixed_next = fixed_dec;
                if (fixed_dec == 3'd0) begin
                    phase_next = gzhs_pkg::PH_IDLE;
                    done       = 1'b1;
                end
            end
            gzhs_pkg::PH_ERROR: begin
            end
            default: begin
                // unused codes fall back to idle
                phase_next = gzhs_pkg::PH_IDLE;
                ph_out     = gzhs_pkg::PH_IDLE;
            end
        endcase
        // XLEN and CRC both count two bytes in the fixed counter
        if (nx == gzhs_pkg::PH_XLEN || nx == gzhs_pkg::PH_CRC)
            fixed_next = gzhs_pkg::TWO_BYTES;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= gzhs_pkg::PH_IDLE;
            trail_reg <= 4'd0;
            fixed_reg <= 3'd0;
            flag_reg  <= 8'd0;
            extra_reg <= 16'd0;
            idok_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            trail_reg <= trail_next;
            fixed_reg <= fixed_next;
            flag_reg  <= flag_next;
            extra_reg <= extra_next;
            idok_reg  <= idok_next;
        end
    end

    assign result.header_done  = done;
    assign result.bad_magic    = bad;
    assign result.phase        = ph_out;
    assign result.header_flags = flag_next;

endmodule : gzhs_parser

`default_nettype wire

### rtl/gzip_header_skipper_unit.sv
// Top level of the gzip header skipper: input register, parser step, result register.
// Depends on gzhs_pkg and gzhs_parser.
// Path: input register, parser step, result register; while the result stage is stalled
// by m_tready low, the input item waits in the input register and s_tready drops.
// Throughput: one byte per cycle unless stalled; the parser state updates once per byte.
// Reset (aresetn, synchronous, active low): both stages empty, parse state idle,
// captured flags zero.
`default_nettype none

module gzip_header_skipper_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [11:8] skip_count, rest 0
    input  wire logic [0:0]  s_tuser,   // [0] begin_req
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [3:0] phase, [11:4] header_flags, rest 0
    output logic [0:0]       m_tuser,   // [0] bad_magic
    output logic             m_tlast    // header_done
);

    // input stage
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  skip_reg;
    logic        begin_reg;

    // result stage
    logic                  out_valid_reg;
    gzhs_pkg::gzhs_result_t res_reg;
    gzhs_pkg::gzhs_result_t res_comb;

    logic advance;   // input stage item moves into the result stage
    logic s_xfer;

    // Result stage frees when empty or drained this cycle; the input
    // stage refills in the same cycle it hands its item on.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            byte_reg  <= s_tdata[7:0];
            skip_reg  <= s_tdata[11:8];
            begin_reg <= s_tuser[0];
        end
    end

    // parse state advances exactly once per byte, when it is committed
    gzhs_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .data_byte  (byte_reg),
        .begin_req  (begin_reg),
        .skip_count (skip_reg),
        .result     (res_comb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_comb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg.header_flags, res_reg.phase};
    assign m_tuser  = res_reg.bad_magic;
    assign m_tlast  = res_reg.header_done;

endmodule : gzip_header_skipper_unit

`default_nettype wire
